### hw/rtl/tria_pkg.sv
// ----------------------------------------------------------------------------
// tria_pkg
// shared constants and types for the two-resource interval assigner
// ----------------------------------------------------------------------------
package tria_pkg;

  localparam int MAX_INTERVALS_DEF = 64;
  localparam int TIME_BITS_DEF     = 16;
  localparam int INDEX_BITS        = 6;

  typedef struct packed {
    logic ins;
    logic shl;
    logic clr;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_LOAD   = 4'b0001,
    ST_ASSIGN = 4'b0010,
    ST_READ   = 4'b0100,
    ST_OUT    = 4'b1000
  } state_t;

endpackage

### hw/rtl/tria_ram.sv
// ----------------------------------------------------------------------------
// tria_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module tria_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/tria_cell.sv
// ----------------------------------------------------------------------------
// tria_cell
// one slot of the sorting chain: holds an interval; clears, inserts or shifts left
// ----------------------------------------------------------------------------
module tria_cell #(
  parameter int TIME_BITS = tria_pkg::TIME_BITS_DEF,
  parameter int IDX_W     = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tria_pkg::cell_ctl_t   ctl,
  input  logic [TIME_BITS-1:0]  new_start,
  input  logic [TIME_BITS-1:0]  new_finish,
  input  logic [IDX_W-1:0]      new_idx,
  input  logic                  l_valid,
  input  logic [TIME_BITS-1:0]  l_start,
  input  logic [TIME_BITS-1:0]  l_finish,
  input  logic [IDX_W-1:0]      l_idx,
  input  logic                  l_g,
  input  logic                  r_valid,
  input  logic [TIME_BITS-1:0]  r_start,
  input  logic [TIME_BITS-1:0]  r_finish,
  input  logic [IDX_W-1:0]      r_idx,
  output logic                  valid,
  output logic [TIME_BITS-1:0]  start,
  output logic [TIME_BITS-1:0]  finish,
  output logic [IDX_W-1:0]      idx,
  output logic                  g
);

  logic                 valid_r, valid_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic [TIME_BITS-1:0] finish_r, finish_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;

  // new item goes at or before this slot
  assign g = !valid_r || (new_start < start_r);

  always_comb begin
    valid_nxt  = valid_r;
    start_nxt  = start_r;
    finish_nxt = finish_r;
    idx_nxt    = idx_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.shl) begin
      valid_nxt  = r_valid;
      start_nxt  = r_start;
      finish_nxt = r_finish;
      idx_nxt    = r_idx;
    end else if (ctl.ins && g) begin
      valid_nxt = 1'b1;
      if (l_g) begin
        valid_nxt  = l_valid;
        start_nxt  = l_start;
        finish_nxt = l_finish;
        idx_nxt    = l_idx;
      end else begin
        start_nxt  = new_start;
        finish_nxt = new_finish;
        idx_nxt    = new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    start_r  <= start_nxt;
    finish_r <= finish_nxt;
    idx_r    <= idx_nxt;
  end

  assign valid  = valid_r;
  assign start  = start_r;
  assign finish = finish_r;
  assign idx    = idx_r;

endmodule

### hw/rtl/two_resource_interval_assigner.sv
// load: accepted requests are sorted into the chain while it has room; after the
// last request the greedy pass runs until the chain is empty or an interval fits
// neither resource; results: a ram read state then an output state each (output only if impossible), plus stalls
// new requests are refused from the last request until the final result goes
// synchronous active-low reset empties the chain and clears count and flags
// ----------------------------------------------------------------------------
// two_resource_interval_assigner
// sorts intervals in a chain of cells, assigns them greedily to two resources
// ----------------------------------------------------------------------------
module two_resource_interval_assigner #(
  parameter int MAX_INTERVALS = tria_pkg::MAX_INTERVALS_DEF,
  parameter int TIME_BITS     = tria_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [TIME_BITS-1:0]           in_start_time,
  input  logic [TIME_BITS-1:0]           in_finish_time,
  input  logic                           in_last_interval,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tria_pkg::INDEX_BITS-1:0] out_item_index,
  output logic                           out_resource,
  output logic                           out_impossible,
  output logic                           out_overflowed,
  output logic                           out_last_result
);

  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int XW    = CNT_W + tria_pkg::INDEX_BITS;

  tria_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;
  logic                ovf_r, ovf_nxt;
  logic                imp_r, imp_nxt;
  logic [TIME_BITS-1:0] free0_r, free0_nxt;
  logic [TIME_BITS-1:0] free1_r, free1_nxt;
  tria_pkg::cell_ctl_t ctl;

  logic                 c_valid  [MAX_INTERVALS];
  logic [TIME_BITS-1:0] c_start  [MAX_INTERVALS];
  logic [TIME_BITS-1:0] c_finish [MAX_INTERVALS];
  logic [IDX_W-1:0]     c_idx    [MAX_INTERVALS];
  logic                 c_g      [MAX_INTERVALS];

  logic                 accept, room, last_out, wr_en, wr_res, rd_res;
  logic [XW-1:0]        j_ext;

  assign accept   = in_valid && in_ready;
  assign room     = cnt_r < CNT_W'(MAX_INTERVALS);
  assign last_out = imp_r || (CNT_W'(j_r + 1'b1) == cnt_r);

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_chain
    logic                 lv, lg, rv;
    logic [TIME_BITS-1:0] ls, lf, rs, rf;
    logic [IDX_W-1:0]     li, ri;
    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign lg = 1'b0;
      assign ls = in_start_time;
      assign lf = in_finish_time;
      assign li = cnt_r[IDX_W-1:0];
    end else begin : g_mid
      assign lv = c_valid[i-1];
      assign lg = c_g[i-1];
      assign ls = c_start[i-1];
      assign lf = c_finish[i-1];
      assign li = c_idx[i-1];
    end
    if (i == MAX_INTERVALS - 1) begin : g_tail
      assign rv = 1'b0;
      assign rs = c_start[i];
      assign rf = c_finish[i];
      assign ri = c_idx[i];
    end else begin : g_body
      assign rv = c_valid[i+1];
      assign rs = c_start[i+1];
      assign rf = c_finish[i+1];
      assign ri = c_idx[i+1];
    end
    tria_cell #(.TIME_BITS(TIME_BITS), .IDX_W(IDX_W)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_start  (in_start_time),
      .new_finish (in_finish_time),
      .new_idx    (cnt_r[IDX_W-1:0]),
      .l_valid    (lv),
      .l_start    (ls),
      .l_finish   (lf),
      .l_idx      (li),
      .l_g        (lg),
      .r_valid    (rv),
      .r_start    (rs),
      .r_finish   (rf),
      .r_idx      (ri),
      .valid      (c_valid[i]),
      .start      (c_start[i]),
      .finish     (c_finish[i]),
      .idx        (c_idx[i]),
      .g          (c_g[i])
    );
  end

  tria_ram #(.WIDTH(1), .DEPTH(MAX_INTERVALS)) u_assign_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (c_idx[0]),
    .wr_data (wr_res),
    .rd_addr (j_r[IDX_W-1:0]),
    .rd_data (rd_res)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    j_nxt     = j_r;
    ovf_nxt   = ovf_r;
    imp_nxt   = imp_r;
    free0_nxt = free0_r;
    free1_nxt = free1_r;
    ctl       = '0;
    wr_en     = 1'b0;
    wr_res    = 1'b0;
    unique case (state_r)
      tria_pkg::ST_LOAD: begin
        if (accept) begin
          if (room) begin
            ctl.ins = 1'b1;
            cnt_nxt = CNT_W'(cnt_r + 1'b1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_interval) begin
            state_nxt = tria_pkg::ST_ASSIGN;
          end
        end
      end
      tria_pkg::ST_ASSIGN: begin
        if (!c_valid[0]) begin
          j_nxt     = '0;
          state_nxt = tria_pkg::ST_READ;
        end else if (free0_r <= c_start[0]) begin
          wr_en     = 1'b1;
          free0_nxt = c_finish[0];
          ctl.shl   = 1'b1;
        end else if (free1_r <= c_start[0]) begin
          wr_en     = 1'b1;
          wr_res    = 1'b1;
          free1_nxt = c_finish[0];
          ctl.shl   = 1'b1;
        end else begin
          imp_nxt   = 1'b1;
          state_nxt = tria_pkg::ST_OUT;
        end
      end
      tria_pkg::ST_READ: begin
        state_nxt = tria_pkg::ST_OUT;
      end
      tria_pkg::ST_OUT: begin
        if (out_ready) begin
          if (last_out) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            imp_nxt   = 1'b0;
            free0_nxt = '0;
            free1_nxt = '0;
            ctl.clr   = 1'b1;
            state_nxt = tria_pkg::ST_LOAD;
          end else begin
            j_nxt     = CNT_W'(j_r + 1'b1);
            state_nxt = tria_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_nxt = tria_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tria_pkg::ST_LOAD;
      cnt_r   <= '0;
      j_r     <= '0;
      ovf_r   <= 1'b0;
      imp_r   <= 1'b0;
      free0_r <= '0;
      free1_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      j_r     <= j_nxt;
      ovf_r   <= ovf_nxt;
      imp_r   <= imp_nxt;
      free0_r <= free0_nxt;
      free1_r <= free1_nxt;
    end
  end

  assign j_ext           = {{tria_pkg::INDEX_BITS{1'b0}}, j_r};
  assign in_ready        = (state_r == tria_pkg::ST_LOAD);
  assign out_valid       = (state_r == tria_pkg::ST_OUT);
  assign out_item_index  = imp_r ? '0 : j_ext[tria_pkg::INDEX_BITS-1:0];
  assign out_resource    = imp_r ? 1'b0 : rd_res;
  assign out_impossible  = imp_r;
  assign out_overflowed  = ovf_r;
  assign out_last_result = last_out;

endmodule

### hw/rtl/tria_checker.sv
// ----------------------------------------------------------------------------
// tria_checker
// port-level checks on the two-resource interval assigner
// ----------------------------------------------------------------------------
module tria_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_item_index,
  input logic       out_resource,
  input logic       out_impossible,
  input logic       out_last_result
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_index) &&
      $stable(out_resource) && $stable(out_last_result))
    else $error("result changed while stalled");

  // impossible is a single closing result
  a_imp_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_impossible |-> out_last_result && out_item_index == 6'd0 &&
      !out_resource)
    else $error("bad impossible result");

  // no new request taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken during result phase");

  // after the final result is taken, requests are open again
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_result |=> in_ready)
    else $error("not ready after run");

endmodule

bind two_resource_interval_assigner tria_checker u_tria_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_item_index  (out_item_index),
  .out_resource    (out_resource),
  .out_impossible  (out_impossible),
  .out_last_result (out_last_result)
);
